FILE: hw/rtl/bed_pkg.sv
package bed_pkg;

  localparam int NBANDS    = 7;
  localparam int SUM_OUT_W = 24;
  localparam int MAG_W     = 15;
  localparam int Q16_W     = 17;
  localparam int PROD_W    = 41;

  localparam logic [Q16_W-1:0]     Q16_ONE  = 17'h10000;
  localparam logic [PROD_W-1:0]    HALF_Q16 = 41'd32768;
  localparam logic [SUM_OUT_W-1:0] MAX24    = 24'hFFFFFF;

  // Band edges: first counted bin, then the last bin position of each band below brilliance
  localparam int BIN_FIRST   = 2;
  localparam int BIN_SUB_HI  = 5;
  localparam int BIN_BASS_HI = 21;
  localparam int BIN_LMID_HI = 42;
  localparam int BIN_MID_HI  = 170;
  localparam int BIN_UMID_HI = 341;
  localparam int BIN_PRES_HI = 512;

  // Band codes; BAND_NONE marks an ignored bin
  localparam int BAND_W = 3;
  localparam logic [BAND_W-1:0] BAND_SUB  = 3'd0;
  localparam logic [BAND_W-1:0] BAND_BASS = 3'd1;
  localparam logic [BAND_W-1:0] BAND_LMID = 3'd2;
  localparam logic [BAND_W-1:0] BAND_MID  = 3'd3;
  localparam logic [BAND_W-1:0] BAND_UMID = 3'd4;
  localparam logic [BAND_W-1:0] BAND_PRES = 3'd5;
  localparam logic [BAND_W-1:0] BAND_BRIL = 3'd6;
  localparam logic [BAND_W-1:0] BAND_NONE = 3'd7;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 24;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOOM_EN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOOM    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUB_TH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_TH  = 3'd4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic signed [15:0] bin_value;
    logic               last_bin;
    logic [Q16_W-1:0]   decay_factor;
  } in_t;

  typedef struct packed {
    logic [SUM_OUT_W-1:0] sub_bass_sum;
    logic [SUM_OUT_W-1:0] bass_sum;
    logic [SUM_OUT_W-1:0] low_mid_sum;
    logic [SUM_OUT_W-1:0] mid_sum;
    logic [SUM_OUT_W-1:0] upper_mid_sum;
    logic [SUM_OUT_W-1:0] presence_sum;
    logic [SUM_OUT_W-1:0] brilliance_sum;
    logic [NBANDS-1:0]    band_flags;
    logic [SUM_OUT_W-1:0] reaction_level;
    logic [15:0]          bloom_level;
    logic                 angle_reset;
  } out_t;

  typedef struct packed {
    logic [BAND_W-1:0] band;
    logic [MAG_W-1:0]  mag;
    logic              last;
    logic [Q16_W-1:0]  decay;
  } q_entry_t;

  typedef struct packed {
    logic [NBANDS-1:0][SUM_OUT_W-1:0] sums;
    logic [Q16_W-1:0]                 decay;
  } frame_t;

  typedef struct packed {
    logic [Q16_W-1:0]     alpha;
    logic                 bloom_en;
    logic [15:0]          bloom_int;
    logic [SUM_OUT_W-1:0] sub_th;
    logic [SUM_OUT_W-1:0] band_th;
  } cfg_t;

  // Values above 1.0 act as 1.0
  function automatic logic [Q16_W-1:0] clamp_q16(input logic [Q16_W-1:0] v);
    return (v > Q16_ONE) ? Q16_ONE : v;
  endfunction

endpackage

FILE: hw/rtl/bed_front.sv
module bed_front #(
  parameter int NUM_BINS = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  bed_pkg::in_t     in_data,
  input  logic             q_full,
  output logic             q_push,
  output bed_pkg::q_entry_t q_wdata
);
  import bed_pkg::*;

  localparam int POS_W = $clog2(NUM_BINS);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(NUM_BINS - 1);

  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  pos_nxt;
  logic [BAND_W-1:0] band;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Classify the current bin position into a band
  always_comb begin
    if (pos_r < POS_W'(BIN_FIRST)) begin
      band = BAND_NONE;
    end else if (pos_r <= POS_W'(BIN_SUB_HI)) begin
      band = BAND_SUB;
    end else if (pos_r <= POS_W'(BIN_BASS_HI)) begin
      band = BAND_BASS;
    end else if (pos_r <= POS_W'(BIN_LMID_HI)) begin
      band = BAND_LMID;
    end else if (pos_r <= POS_W'(BIN_MID_HI)) begin
      band = BAND_MID;
    end else if (pos_r <= POS_W'(BIN_UMID_HI)) begin
      band = BAND_UMID;
    end else if (pos_r <= POS_W'(BIN_PRES_HI)) begin
      band = BAND_PRES;
    end else begin
      band = BAND_BRIL;
    end
  end

  // Rectify: negative differences count as zero
  always_comb begin
    q_wdata.band  = band;
    q_wdata.mag   = in_data.bin_value[15] ? '0 : in_data.bin_value[MAG_W-1:0];
    q_wdata.last  = in_data.last_bin;
    q_wdata.decay = in_data.decay_factor;
  end

  // Advance the position, hold at the top, restart after the last bin
  always_comb begin
    if (in_data.last_bin) begin
      pos_nxt = '0;
    end else if (pos_r < POS_MAX) begin
      pos_nxt = pos_r + POS_W'(1);
    end else begin
      pos_nxt = pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (q_push) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

FILE: hw/rtl/bed_queue.sv
module bed_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bed_pkg::q_entry_t wdata,
  output logic              full,
  output logic              valid,
  output bed_pkg::q_entry_t rdata,
  input  logic              pop
);
  import bed_pkg::*;

  q_entry_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic [QPTR_W:0]   count_nxt;

  assign full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid = (count_r != '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QPTR_W+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QPTR_W+1)'(1);
    end
  end

  // Store the request
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

FILE: hw/rtl/bed_back.sv
module bed_back #(
  parameter int SUM_BITS = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  bed_pkg::q_entry_t q_rdata,
  output logic              q_pop,
  input  logic              react_idle,
  output logic              frm_valid,
  output bed_pkg::frame_t   frm
);
  import bed_pkg::*;

  localparam int EXT_W = (SUM_BITS > SUM_OUT_W) ? SUM_BITS : SUM_OUT_W;

  logic [SUM_BITS-1:0] acc_r   [NBANDS];
  logic [SUM_BITS-1:0] acc_nxt [NBANDS];

  // A last bin waits until the reaction unit has finished the previous frame
  assign q_pop     = q_valid && (!q_rdata.last || react_idle);
  assign frm_valid = q_pop && q_rdata.last;

  // One saturating adder per band lane
  always_comb begin
    logic [SUM_BITS:0] sum_full;
    logic [EXT_W-1:0]  ext;
    frm.decay = q_rdata.decay;
    for (int i = 0; i < NBANDS; i++) begin
      sum_full = {1'b0, acc_r[i]} + (SUM_BITS+1)'(q_rdata.mag);
      if (q_rdata.band == BAND_W'(i)) begin
        acc_nxt[i] = sum_full[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_full[SUM_BITS-1:0];
      end else begin
        acc_nxt[i] = acc_r[i];
      end
      ext         = EXT_W'(acc_nxt[i]);
      frm.sums[i] = (ext > EXT_W'(MAX24)) ? MAX24 : ext[SUM_OUT_W-1:0];
    end
  end

  // Accumulate, clear after the frame is handed over
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NBANDS; i++) begin
        acc_r[i] <= '0;
      end
    end else if (q_pop) begin
      for (int i = 0; i < NBANDS; i++) begin
        acc_r[i] <= q_rdata.last ? '0 : acc_nxt[i];
      end
    end
  end

endmodule

FILE: hw/rtl/bed_react.sv
module bed_react (
  input  logic            clk,
  input  logic            rst_n,
  input  bed_pkg::cfg_t   cfg,
  input  logic            frm_valid,
  input  bed_pkg::frame_t frm,
  output logic            idle,
  output logic            out_valid,
  input  logic            out_ready,
  output bed_pkg::out_t   out_data
);
  import bed_pkg::*;

  // Stage valids, one frame in flight at a time
  logic v1_r, v2_r, v3_r;
  logic out_valid_r;
  logic out_free;

  // Reaction state
  logic [SUM_OUT_W-1:0] target_r;
  logic [SUM_OUT_W-1:0] smoothed_r;
  logic [SUM_OUT_W-1:0] target_nxt;
  logic [SUM_OUT_W-1:0] smoothed_nxt;

  // Stage 1: captured frame
  logic [NBANDS-1:0][SUM_OUT_W-1:0] s1_sums_r;
  logic [Q16_W-1:0]                 s1_decay_r;

  // Stage 2: flags and raised target
  logic [NBANDS-1:0][SUM_OUT_W-1:0] s2_sums_r;
  logic [NBANDS-1:0]                s2_flags_r;
  logic                             s2_fired_r;
  logic [SUM_OUT_W-1:0]             s2_tgt_r;
  logic [Q16_W-1:0]                 s2_alpha_r;
  logic [Q16_W-1:0]                 s2_decay_r;
  logic [NBANDS-1:0]                flags_nxt;
  logic                             fired_nxt;
  logic [SUM_OUT_W:0]               tgt_sum;
  logic [SUM_OUT_W-1:0]             tgt_nxt;

  // Stage 3: products
  logic [NBANDS-1:0][SUM_OUT_W-1:0] s3_sums_r;
  logic [NBANDS-1:0]                s3_flags_r;
  logic                             s3_fired_r;
  logic [PROD_W-1:0]                p_keep_r;
  logic [PROD_W-1:0]                p_new_r;
  logic [PROD_W-1:0]                p_decay_r;
  logic [PROD_W-1:0]                smooth_acc;
  logic [PROD_W-1:0]                decay_acc;

  out_t out_r;

  assign idle      = !v1_r && !v2_r && !v3_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  // Threshold flags and the bass-driven target bump
  always_comb begin
    for (int i = 0; i < NBANDS; i++) begin
      flags_nxt[i] = (i == 0) ? (s1_sums_r[i] > cfg.sub_th) : (s1_sums_r[i] > cfg.band_th);
    end
    fired_nxt = flags_nxt[BAND_BASS] && cfg.bloom_en;
    tgt_sum   = {1'b0, target_r} + (SUM_OUT_W+1)'(HALF_Q16);
    if (!fired_nxt) begin
      tgt_nxt = target_r;
    end else if (tgt_sum[SUM_OUT_W]) begin
      tgt_nxt = MAX24;
    end else begin
      tgt_nxt = tgt_sum[SUM_OUT_W-1:0];
    end
  end

  // Round to nearest and drop the fraction
  always_comb begin
    smooth_acc   = p_keep_r + p_new_r + HALF_Q16;
    decay_acc    = p_decay_r + HALF_Q16;
    smoothed_nxt = smooth_acc[SUM_OUT_W+15:16];
    target_nxt   = decay_acc[SUM_OUT_W+15:16];
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (frm_valid) begin
      s1_sums_r  <= frm.sums;
      s1_decay_r <= frm.decay;
    end
    if (v1_r) begin
      s2_sums_r  <= s1_sums_r;
      s2_flags_r <= flags_nxt;
      s2_fired_r <= fired_nxt;
      s2_tgt_r   <= tgt_nxt;
      s2_alpha_r <= clamp_q16(cfg.alpha);
      s2_decay_r <= clamp_q16(s1_decay_r);
    end
    if (v2_r) begin
      s3_sums_r  <= s2_sums_r;
      s3_flags_r <= s2_flags_r;
      s3_fired_r <= s2_fired_r;
      p_keep_r   <= PROD_W'(smoothed_r) * PROD_W'(Q16_ONE - s2_alpha_r);
      p_new_r    <= PROD_W'(s2_tgt_r) * PROD_W'(s2_alpha_r);
      p_decay_r  <= PROD_W'(s2_tgt_r) * PROD_W'(s2_decay_r);
    end
    if (v3_r && out_free) begin
      out_r.sub_bass_sum   <= s3_sums_r[BAND_SUB];
      out_r.bass_sum       <= s3_sums_r[BAND_BASS];
      out_r.low_mid_sum    <= s3_sums_r[BAND_LMID];
      out_r.mid_sum        <= s3_sums_r[BAND_MID];
      out_r.upper_mid_sum  <= s3_sums_r[BAND_UMID];
      out_r.presence_sum   <= s3_sums_r[BAND_PRES];
      out_r.brilliance_sum <= s3_sums_r[BAND_BRIL];
      out_r.band_flags     <= s3_flags_r;
      out_r.reaction_level <= smoothed_nxt;
      out_r.bloom_level    <= s3_fired_r ? cfg.bloom_int : '0;
      out_r.angle_reset    <= s3_fired_r;
    end
  end

  // Control and reaction state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
      target_r    <= '0;
      smoothed_r  <= '0;
    end else begin
      v1_r <= frm_valid;
      v2_r <= v1_r;
      if (v2_r) begin
        v3_r <= 1'b1;
      end else if (out_free) begin
        v3_r <= 1'b0;
      end
      if (v3_r && out_free) begin
        out_valid_r <= 1'b1;
        target_r    <= target_nxt;
        smoothed_r  <= smoothed_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({v1_r, v2_r, v3_r}))
    else $error("more than one frame in the reaction unit");

  a_frame_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    frm_valid |-> idle)
    else $error("frame handed over while reaction unit busy");

  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |=> v2_r)
    else $error("stage one did not advance");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && out_free) |=> out_valid_r && !v3_r)
    else $error("finished frame did not reach the output register");

endmodule

FILE: hw/rtl/band_energy_beat_detector.sv
// Band energy beat detector. Takes one spectral-difference bin per cycle while
// the queue has room, sorts it by its position in the frame into seven saturating
// band sums, and on the bin marked last gives one result: the sums, their threshold
// flags and the smoothed bass reaction. A front end rectifies and classifies each
// bin into a four-entry queue; the back end adds one bin per cycle into the band
// lanes unless a last bin is held. A last bin starts a reaction sequence (flags and
// target bump, three 24x17 multipliers, rounding), and the next last bin waits in
// the queue until it has finished, so frames of four bins or more run at one bin
// per cycle while the output is not held. A result is offered from the output
// register once its frame has passed the capture, flag and product stages.
// Configuration writes are taken every cycle and must be made while idle.
module band_energy_beat_detector #(
  parameter int NUM_BINS = 1024,
  parameter int SUM_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bed_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bed_pkg::out_t                     out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bed_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bed_pkg::CFG_W-1:0]         cfg_data
);
  import bed_pkg::*;

  cfg_t     cfg_r;
  logic     q_push, q_full, q_valid, q_pop;
  q_entry_t q_wdata, q_rdata;
  logic     react_idle;
  logic     frm_valid;
  frame_t   frm;

  assign cfg_ready = 1'b1;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha     <= Q16_ONE;
      cfg_r.bloom_en  <= 1'b0;
      cfg_r.bloom_int <= '0;
      cfg_r.sub_th    <= SUM_OUT_W'(50);
      cfg_r.band_th   <= SUM_OUT_W'(100);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ALPHA:    cfg_r.alpha     <= cfg_data[Q16_W-1:0];
        REG_BLOOM_EN: cfg_r.bloom_en  <= cfg_data[0];
        REG_BLOOM:    cfg_r.bloom_int <= cfg_data[15:0];
        REG_SUB_TH:   cfg_r.sub_th    <= cfg_data[SUM_OUT_W-1:0];
        REG_BAND_TH:  cfg_r.band_th   <= cfg_data[SUM_OUT_W-1:0];
        default: ;
      endcase
    end
  end

  bed_front #(.NUM_BINS(NUM_BINS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  bed_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .valid (q_valid),
    .rdata (q_rdata),
    .pop   (q_pop)
  );

  bed_back #(.SUM_BITS(SUM_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .react_idle (react_idle),
    .frm_valid  (frm_valid),
    .frm        (frm)
  );

  bed_react u_react (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .frm_valid (frm_valid),
    .frm       (frm),
    .idle      (react_idle),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
